// ===== rtl/srfp_pkg.sv =====
// Shared types, character codes and field slot lookups for the SAM record field parser.
`timescale 1ns / 1ps
package srfp_pkg;

  localparam int MaxLineDefault = 4096;
  localparam int MaxFields      = 12;
  localparam int OffW           = 12;
  localparam int FidxW          = 4;
  localparam int NumW           = 32;
  localparam int NumSlots       = 5;
  localparam int OffSlots       = 6;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_SEP   = 3'd1;
  localparam logic [2:0] KIND_SPACE = 3'd2;
  localparam logic [2:0] KIND_SIGN  = 3'd3;
  localparam logic [2:0] KIND_DIGIT = 3'd4;

  typedef struct packed {
    logic             active;
    logic [2:0]       kind;
    logic             neg;
    logic [3:0]       digit;
    logic [FidxW-1:0] fidx;
    logic [OffW-1:0]  next_off;
    logic [OffW-1:0]  kept_len;
    logic             last;
  } token_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       idx;
  } slot_t;

  typedef struct packed {
    logic [FidxW-1:0] field_count;
    logic [OffW-1:0]  optional_start;
    logic [OffW-1:0]  quality_start;
    logic [OffW-1:0]  sequence_start;
    logic [OffW-1:0]  mate_refname_start;
    logic [OffW-1:0]  cigar_start;
    logic [OffW-1:0]  refname_start;
    logic [31:0]      template_length;
    logic [31:0]      mate_position;
    logic [7:0]       map_quality;
    logic [31:0]      position;
    logic [15:0]      flag_value;
  } result_t;

  function automatic slot_t num_slot(input logic [FidxW-1:0] f);
    slot_t s;
    s = '{hit: 1'b1, idx: 3'd0};
    case (f)
      4'd2: s.idx = 3'd0;
      4'd4: s.idx = 3'd1;
      4'd5: s.idx = 3'd2;
      4'd8: s.idx = 3'd3;
      4'd9: s.idx = 3'd4;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

  function automatic slot_t off_slot(input logic [FidxW-1:0] f);
    slot_t s;
    s = '{hit: 1'b1, idx: 3'd0};
    case (f)
      4'd3:  s.idx = 3'd0;
      4'd6:  s.idx = 3'd1;
      4'd7:  s.idx = 3'd2;
      4'd10: s.idx = 3'd3;
      4'd11: s.idx = 3'd4;
      4'd12: s.idx = 3'd5;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/srfp_front.sv =====
// Front end: tracks byte offset, field index and kept length, and classifies each byte.
`timescale 1ns / 1ps
module srfp_front import srfp_pkg::*; #(
  parameter int MaxLine = MaxLineDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       full_i,
  output logic       push_o,
  output token_t     token_o
);

  localparam int OW = $clog2(MaxLine);

  logic [OW-1:0]    offset_q, offset_d, off_inc;
  logic [FidxW-1:0] fidx_q, fidx_d;
  logic [OffW-1:0]  kept_q, kept_d;
  logic             active, sep, keep, accept;
  logic [2:0]       kind;

  assign off_inc = offset_q + 1'b1;
  assign active  = offset_q < OW'(MaxLine - 1);
  assign sep     = active && (byte_i == CHAR_TAB) && (fidx_q < FidxW'(MaxFields));
  assign keep    = ((byte_i != CHAR_CR) && (byte_i != CHAR_LF)) || (offset_q == '0);

  always_comb begin
    if (sep) begin
      kind = KIND_SEP;
    end else if ((byte_i == CHAR_SPACE) || (byte_i == CHAR_CR) || (byte_i == CHAR_LF) ||
                 (byte_i == CHAR_VT) || (byte_i == CHAR_FF)) begin
      kind = KIND_SPACE;
    end else if ((byte_i == CHAR_PLUS) || (byte_i == CHAR_MINUS)) begin
      kind = KIND_SIGN;
    end else if ((byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE)) begin
      kind = KIND_DIGIT;
    end else begin
      kind = KIND_OTHER;
    end
  end

  assign kept_d = (active && keep) ? OffW'(off_inc) : kept_q;

  assign token_o = '{
    active:   active,
    kind:     kind,
    neg:      (byte_i == CHAR_MINUS),
    digit:    4'(byte_i - CHAR_ZERO),
    fidx:     fidx_q,
    next_off: OffW'(off_inc),
    kept_len: kept_d,
    last:     last_i
  };

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept;

  always_comb begin
    offset_d = offset_q;
    fidx_d   = fidx_q;
    if (last_i) begin
      offset_d = '0;
      fidx_d   = FidxW'(1);
    end else if (active) begin
      offset_d = off_inc;
      fidx_d   = sep ? fidx_q + 1'b1 : fidx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      fidx_q   <= FidxW'(1);
      kept_q   <= '0;
    end else if (accept) begin
      offset_q <= offset_d;
      fidx_q   <= fidx_d;
      kept_q   <= last_i ? '0 : kept_d;
    end
  end

endmodule

// ===== rtl/srfp_fifo.sv =====
// Two-entry token queue between the front end and the back end.
`timescale 1ns / 1ps
module srfp_fifo import srfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output token_t data_o
);

  token_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/srfp_back.sv =====
// Back end: number parsing, field bookkeeping and the registered result.
`timescale 1ns / 1ps
module srfp_back import srfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  token_t  token_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [NumW-1:0]  acc_q, acc_d;
  logic [1:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [NumW-1:0]  nums_q [NumSlots];
  logic [NumW-1:0]  nums_d [NumSlots];
  logic [NumW-1:0]  nums_fin [NumSlots];
  logic [OffW-1:0]  offs_q [OffSlots];
  logic [OffW-1:0]  offs_d [OffSlots];
  logic [FidxW-1:0] fidx_after;
  logic [OffW-1:0]  opt;
  logic [NumW-1:0]  acc_ten;
  logic             valid_q, out_free, is_sep;
  slot_t            ns_cur, ns_after, os_next;
  result_t          result_d, result_q;

  assign out_free = !valid_q || ready_i;
  assign pop_o    = !empty_i && (out_free || !token_i.last);
  assign is_sep   = token_i.active && (token_i.kind == KIND_SEP);
  assign fidx_after = is_sep ? token_i.fidx + 1'b1 : token_i.fidx;
  assign ns_cur   = num_slot(token_i.fidx);
  assign ns_after = num_slot(fidx_after);
  assign os_next  = off_slot(token_i.fidx + 1'b1);
  assign acc_ten  = {acc_q[NumW-4:0], 3'b000} + {acc_q[NumW-2:0], 1'b0};

  always_comb begin
    acc_d   = acc_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    nums_d  = nums_q;
    offs_d  = offs_q;
    if (is_sep) begin
      if (ns_cur.hit) begin
        nums_d[ns_cur.idx] = neg_q ? (NumW'(0) - acc_q) : acc_q;
      end
      if (os_next.hit) begin
        offs_d[os_next.idx] = token_i.next_off;
      end
      acc_d   = '0;
      phase_d = PH_SKIP;
      neg_d   = 1'b0;
    end else if (token_i.active && ns_cur.hit) begin
      case (phase_q)
        PH_SKIP: begin
          case (token_i.kind)
            KIND_SPACE: phase_d = PH_SKIP;
            KIND_SIGN: begin
              neg_d   = token_i.neg;
              phase_d = PH_DIGITS;
            end
            KIND_DIGIT: begin
              acc_d   = NumW'(token_i.digit);
              phase_d = PH_DIGITS;
            end
            default: phase_d = PH_DONE;
          endcase
        end
        PH_DIGITS: begin
          if (token_i.kind == KIND_DIGIT) begin
            acc_d = acc_ten + NumW'(token_i.digit);
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_comb begin
    nums_fin = nums_d;
    if (ns_after.hit) begin
      nums_fin[ns_after.idx] = neg_d ? (NumW'(0) - acc_d) : acc_d;
    end
    if (fidx_after >= FidxW'(MaxFields)) begin
      opt = offs_d[5];
    end else if (fidx_after == FidxW'(MaxFields - 1)) begin
      opt = token_i.kept_len;
    end else begin
      opt = '0;
    end
    result_d.flag_value         = nums_fin[0][15:0];
    result_d.position           = nums_fin[1];
    result_d.map_quality        = nums_fin[2][7:0];
    result_d.mate_position      = nums_fin[3];
    result_d.template_length    = nums_fin[4];
    result_d.refname_start      = offs_d[0];
    result_d.cigar_start        = offs_d[1];
    result_d.mate_refname_start = offs_d[2];
    result_d.sequence_start     = offs_d[3];
    result_d.quality_start      = offs_d[4];
    result_d.optional_start     = opt;
    result_d.field_count        = fidx_after;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && token_i.last) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        nums_q[i] <= '0;
      end
      for (int i = 0; i < OffSlots; i++) begin
        offs_q[i] <= '0;
      end
    end else begin
      if (pop_o && token_i.last) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (token_i.last) begin
          acc_q   <= '0;
          phase_q <= PH_SKIP;
          neg_q   <= 1'b0;
          for (int i = 0; i < NumSlots; i++) begin
            nums_q[i] <= '0;
          end
          for (int i = 0; i < OffSlots; i++) begin
            offs_q[i] <= '0;
          end
        end else begin
          acc_q   <= acc_d;
          phase_q <= phase_d;
          neg_q   <= neg_d;
          nums_q  <= nums_d;
          offs_q  <= offs_d;
        end
      end
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/sam_record_field_parser.sv =====
// Top level of the SAM alignment record field parser.
// Accepts one line byte per cycle while the token queue is not full; the single multiply-add
// by ten in the back end sets this rate; results are held in the output register.
// A waiting output result holds the next line's last byte in the queue, which can then fill.
// Reset is asynchronous and active low; it clears all per-line state at once.
`timescale 1ns / 1ps
module sam_record_field_parser import srfp_pkg::*; #(
  parameter int MaxLine = MaxLineDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_in
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // flag_value, position, map_quality, mate_position, template_length, refname_start,
  // cigar_start, mate_refname_start, sequence_start, quality_start, optional_start,
  // field_count, then four zero bits.
  output logic [199:0] m_axis_tdata
);

  token_t  push_tok, pop_tok;
  logic    push, full, pop, empty;
  result_t result;

  srfp_front #(.MaxLine(MaxLine)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .full_i  (full),
    .push_o  (push),
    .token_o (push_tok)
  );

  srfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_tok),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_tok)
  );

  srfp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .token_i  (pop_tok),
    .empty_i  (empty),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {4'b0000, result.field_count, result.optional_start,
                         result.quality_start, result.sequence_start,
                         result.mate_refname_start, result.cigar_start,
                         result.refname_start, result.template_length,
                         result.mate_position, result.map_quality,
                         result.position, result.flag_value};

endmodule
